// ===== sv/pair_sum_complement_lookup_top_defines.svh =====
// Assertion macros shared by the pair-sum complement lookup RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef PAIR_SUM_COMPLEMENT_LOOKUP_TOP_DEFINES_SVH
`define PAIR_SUM_COMPLEMENT_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PSCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pscl check failed");

// Next-cycle implication, disabled while reset is held.
`define PSCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pscl check failed");

`endif

// ===== sv/pscl_pkg.sv =====
// Package for the pair-sum complement lookup: store size, widths and result codes.
// Depends on nothing.
`timescale 1ns / 1ps

package pscl_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int USED_W       = ADDR_W + 1;
    localparam int VAL_W        = 32;
    localparam int IDX_W        = 10;
    localparam int POS_W        = 11;
    localparam int ENTRY_W      = VAL_W + IDX_W;
    localparam int STATUS_W     = 3;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [STATUS_W-1:0] ST_SEARCHING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PAIR      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAIR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

// ===== sv/pair_sum_complement_lookup_top.sv =====
// Top level of the pair-sum complement lookup: control, scan and output register.
// Depends on pscl_pkg, pscl_ram and the assertion macro header.
//
//  channel   | direction | dir/handshake        | payload
//  s_ (in)   | into      | s_tvalid / s_tready  | value, first flag in tuser, last in tlast
//  m_ (out)  | out of    | m_tvalid / m_tready  | status, partner index, element index
//  cfg       | into      | cfg_wr_en            | target sum
//
// A beat scans the store: the stored entries are read one per cycle from the single read
// port of the store memory and compared with the complement and the value. Beats after a
// pair skip the scan and go straight to the final state.
// No clearing pass follows reset; the fill count marks which entries are valid.
// A finished result waits in the final state until the output register is free.
`timescale 1ns / 1ps
`include "pair_sum_complement_lookup_top_defines.svh"

module pair_sum_complement_lookup_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // target_sum
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // element_value
    input  logic [0:0]  s_tuser,       // first_element
    input  logic        s_tlast,       // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // status, partner_index, element_index, zero pad
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [31:0]                     target_reg;
    logic [pscl_pkg::VAL_W-1:0]      val_reg, val_next;
    logic [pscl_pkg::VAL_W-1:0]      comp_reg, comp_next;
    logic                            comp_ok_reg, comp_ok_next;
    logic                            last_reg, last_next;
    logic                            skip_reg, skip_next;
    logic [pscl_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [pscl_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [pscl_pkg::USED_W-1:0]     used_reg, used_next;
    logic                            pair_reg, pair_next;
    logic [pscl_pkg::USED_W-1:0]     cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    logic [pscl_pkg::ADDR_W-1:0]     slot_reg, slot_next;
    logic                            chit_reg, chit_next;
    logic [pscl_pkg::IDX_W-1:0]      cidx_reg, cidx_next;
    logic                            vhit_reg, vhit_next;
    logic [pscl_pkg::ADDR_W-1:0]     vslot_reg, vslot_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [23:0]                     m_tdata_reg, m_tdata_next;

    logic                            in_acc, out_free, rd_en, wr_en;
    logic [pscl_pkg::ADDR_W-1:0]     wr_addr;
    logic [pscl_pkg::ENTRY_W-1:0]    wr_data, rd_data;
    logic [32:0]                     diff;
    logic [pscl_pkg::POS_W-1:0]      pos_base;
    logic [pscl_pkg::USED_W-1:0]     used_base;
    logic                            pair_base;
    logic [pscl_pkg::STATUS_W-1:0]   status;
    logic [pscl_pkg::IDX_W-1:0]      partner;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign diff     = {target_reg[31], target_reg} - {s_tdata[31], s_tdata};
    assign rd_en    = (state_reg == S_SCAN) && (cnt_reg < used_reg);

    pscl_ram #(
        .WIDTH (pscl_pkg::ENTRY_W),
        .DEPTH (pscl_pkg::MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[pscl_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        comp_next     = comp_reg;
        comp_ok_next  = comp_ok_reg;
        last_next     = last_reg;
        skip_next     = skip_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        used_next     = used_reg;
        pair_next     = pair_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        slot_next     = cnt_reg[pscl_pkg::ADDR_W-1:0];
        chit_next     = chit_reg;
        cidx_next     = cidx_reg;
        vhit_next     = vhit_reg;
        vslot_next    = vslot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = used_reg[pscl_pkg::ADDR_W-1:0];
        wr_data       = {idx_reg, val_reg};
        status        = pscl_pkg::ST_SEARCHING;
        partner       = '0;
        pos_base      = s_tuser[0] ? '0 : pos_reg;
        used_base     = s_tuser[0] ? '0 : used_reg;
        pair_base     = s_tuser[0] ? 1'b0 : pair_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    val_next     = s_tdata;
                    comp_next    = diff[31:0];
                    comp_ok_next = (diff[32] == diff[31]);
                    last_next    = s_tlast;
                    skip_next    = pair_base;
                    used_next    = used_base;
                    pair_next    = pair_base;
                    idx_next     = (pos_base > pscl_pkg::POS_W'(pscl_pkg::IDX_MAX))
                                   ? pscl_pkg::IDX_MAX : pos_base[pscl_pkg::IDX_W-1:0];
                    pos_next     = (pos_base < pscl_pkg::POS_MAX) ? pos_base + 1'b1 : pos_base;
                    cnt_next     = '0;
                    chit_next    = 1'b0;
                    vhit_next    = 1'b0;
                    state_next   = pair_base ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    if (comp_ok_reg && rd_data[pscl_pkg::VAL_W-1:0] == comp_reg) begin
                        chit_next = 1'b1;
                        cidx_next = rd_data[pscl_pkg::ENTRY_W-1:pscl_pkg::VAL_W];
                    end
                    if (rd_data[pscl_pkg::VAL_W-1:0] == val_reg) begin
                        vhit_next  = 1'b1;
                        vslot_next = slot_reg;
                    end
                end
                if (!rd_en && !pend_reg) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    priority if (skip_reg) begin
                        status = pscl_pkg::ST_IGNORED;
                    end else if (chit_reg) begin
                        status    = pscl_pkg::ST_PAIR;
                        partner   = cidx_reg;
                        pair_next = 1'b1;
                    end else if (last_reg) begin
                        status = pscl_pkg::ST_NO_PAIR;
                    end else if (vhit_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = vslot_reg;
                    end else if (used_reg < pscl_pkg::USED_W'(pscl_pkg::MAX_ELEMENTS)) begin
                        wr_en     = 1'b1;
                        used_next = used_reg + 1'b1;
                    end else begin
                        status = pscl_pkg::ST_FULL;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, idx_reg, partner, status};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            target_reg   <= '0;
            pos_reg      <= '0;
            used_reg     <= '0;
            pair_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            used_reg     <= used_next;
            pair_reg     <= pair_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        comp_reg    <= comp_next;
        comp_ok_reg <= comp_ok_next;
        last_reg    <= last_next;
        skip_reg    <= skip_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        slot_reg    <= slot_next;
        chit_reg    <= chit_next;
        cidx_reg    <= cidx_next;
        vhit_reg    <= vhit_next;
        vslot_reg   <= vslot_next;
        m_tdata_reg <= m_tdata_next;
    end

    `PSCL_ASSERT_NEXT(a_one_beat_at_a_time, aclk, aresetn, in_acc, !s_tready)
    `PSCL_ASSERT_NOW(a_write_only_at_end, aclk, aresetn, wr_en, state_reg == S_FIN)
    `PSCL_ASSERT_NOW(a_fill_in_range, aclk, aresetn, 1'b1,
                     used_reg <= pscl_pkg::USED_W'(pscl_pkg::MAX_ELEMENTS))
    `PSCL_ASSERT_NEXT(a_result_loaded, aclk, aresetn, state_reg == S_FIN && out_free,
                      m_tvalid && s_tready)

endmodule

// ===== sv/pscl_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module pscl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
